@@ rtl/wgic_pkg.sv @@
// Shared constants, codes and types of the weak-grid impedance classifier.
package wgic_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int FRAC_BITS    = 12;

  localparam int AVG_W = SAMPLE_WIDTH + 8;
  localparam int Z_W   = SAMPLE_WIDTH - 1;
  localparam int T_W   = AVG_W + 5;
  localparam int ONE   = 1 << FRAC_BITS;

  localparam int COUNT_LIMIT = 11;
  localparam int CNT_W       = $clog2(COUNT_LIMIT + 1);

  localparam int V_CONN_LO    = (4 * ONE) / 5;
  localparam int V_CONN_HI    = (6 * ONE - 1) / 5;
  localparam int DV_MIN       = ONE / 1000;
  localparam int DI_MIN       = ONE / 100;
  localparam int Z_WEAK_MAX   = ONE / 100;
  localparam int Z_STRONG_MAX = (ONE - 1) / 3;
  localparam int Z_MARG_MAX   = (ONE - 1) / 2;
  localparam int AVG_DIVISOR  = 10;
  localparam int AVG_ROUND    = 5;

  localparam int DIGIT_BITS  = 2;
  localparam int DNUM_W      = SAMPLE_WIDTH + FRAC_BITS;
  localparam int DDEN_W      = SAMPLE_WIDTH;
  localparam int DIV_CYCLES  = AVG_W / DIGIT_BITS;
  localparam int DCNT_W      = $clog2(DIV_CYCLES + 1);
  localparam int ROOT_W      = Z_W + 1;
  localparam int RAD_W       = 2 * ROOT_W;
  localparam int REM_W       = ROOT_W + 2;
  localparam int SQRT_CYCLES = ROOT_W / DIGIT_BITS;
  localparam int SCNT_W      = $clog2(SQRT_CYCLES + 1);

  localparam logic [Z_W-1:0] Z_MAX = '1;
  localparam logic signed [AVG_W-1:0] AVG_MAX_S = {1'b0, {(AVG_W - 1){1'b1}}};
  localparam logic signed [AVG_W-1:0] AVG_MIN_S = {1'b1, {(AVG_W - 1){1'b0}}};

  localparam logic [1:0] LVL_STRONG   = 2'd0;
  localparam logic [1:0] LVL_MARGINAL = 2'd1;
  localparam logic [1:0] LVL_WEAK     = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

@@ rtl/wgic_div.sv @@
// Shared restoring divider, two quotient bits per cycle, unsigned magnitudes.
module wgic_div
  import wgic_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DNUM_W-1:0] num,
  input  logic [DDEN_W-1:0] den,
  output logic [AVG_W-1:0]  quo,
  output unit_stat_t        stat
);

  logic [DDEN_W-1:0] rem_r, rem_nxt;
  logic [DDEN_W-1:0] den_r, den_nxt;
  logic [AVG_W-1:0]  nq_r, nq_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DDEN_W:0]   part;

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    nq_nxt   = nq_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    part     = '0;
    if (start) begin
      rem_nxt  = DDEN_W'(num >> AVG_W);
      nq_nxt   = num[AVG_W-1:0];
      den_nxt  = den;
      cnt_nxt  = DCNT_W'(DIV_CYCLES);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      for (int k = 0; k < DIGIT_BITS; k++) begin
        part   = {rem_nxt, nq_nxt[AVG_W-1]};
        nq_nxt = {nq_nxt[AVG_W-2:0], 1'b0};
        if (part >= {1'b0, den_r}) begin
          part      = part - {1'b0, den_r};
          nq_nxt[0] = 1'b1;
        end
        rem_nxt = part[DDEN_W-1:0];
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    nq_r  <= nq_nxt;
  end

  assign quo       = nq_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r < den_r))
    else $error("divider remainder reached the divisor");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider finished without running");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider restarted while busy");

endmodule

@@ rtl/wgic_sqrt.sv @@
// Rounded square root of twice a squared magnitude, two root bits per cycle.
module wgic_sqrt
  import wgic_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [Z_W-1:0]    a,
  output logic [ROOT_W:0]   root,
  output unit_stat_t        stat
);

  logic [Z_W-1:0]     a_r, a_nxt;
  logic [RAD_W-1:0]   rad_r, rad_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [ROOT_W-1:0]  root_r, root_nxt;
  logic [SCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               load_r, load_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [2*Z_W-1:0]   sq;
  logic [REM_W-1:0]   tr;
  logic [REM_W-1:0]   trial;

  assign sq = a_r * a_r;

  always_comb begin
    a_nxt    = a_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    load_nxt = 1'b0;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    tr       = '0;
    trial    = '0;
    if (start) begin
      a_nxt    = a;
      load_nxt = 1'b1;
      busy_nxt = 1'b1;
    end else if (load_r) begin
      rad_nxt  = RAD_W'({sq, 1'b0});
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = SCNT_W'(SQRT_CYCLES);
    end else if (busy_r) begin
      for (int k = 0; k < DIGIT_BITS; k++) begin
        tr      = {rem_nxt[REM_W-3:0], rad_nxt[RAD_W-1:RAD_W-2]};
        rad_nxt = {rad_nxt[RAD_W-3:0], 2'b00};
        trial   = {root_nxt, 2'b01};
        if (tr >= trial) begin
          rem_nxt  = tr - trial;
          root_nxt = {root_nxt[ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = tr;
          root_nxt = {root_nxt[ROOT_W-2:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == SCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_r <= 1'b0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      load_r <= load_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r    <= a_nxt;
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign root      = {1'b0, root_r} + (ROOT_W + 1)'(rem_r > REM_W'(root_r));
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  a_load_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    load_r |-> busy_r)
    else $error("root unit loading while idle");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("root unit finished without running");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("root unit restarted while busy");

endmodule

@@ rtl/weak_grid_impedance_classifier.sv @@
// Top level of the weak-grid impedance classifier: sequencer and held state.
//
//   channel | ports                                          | handshake
//   --------+------------------------------------------------+--------------
//   in      | in_grid_voltage, in_current_out, in_pll_locked | valid / ready
//   out     | out_grid_level, out_impedance_estimate,        | valid / ready
//           | out_connected                                  |
//   cfg     | cfg_wdata                                      | cfg_we only
//
// An item with the PLL unlocked goes from S_EVAL straight to S_OUT. A locked item passes
// S_ZCHK and S_LEVEL on its way, through S_SQRT for a root once the count is full and
// the average fits, and, if the delta gate opens, first through two passes of the shared
// divider (two quotient bits a cycle) in S_RATIO and S_DIVAVG. Reset is synchronous; the
// impedance resets to zero until cfg_we loads it. The next item is accepted once the
// result stands in the output register, which holds it while out_ready stays low.
module weak_grid_impedance_classifier
  import wgic_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_grid_voltage,
  input  logic signed [SAMPLE_WIDTH-1:0] in_current_out,
  input  logic                           in_pll_locked,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_grid_level,
  output logic [Z_W-1:0]                 out_impedance_estimate,
  output logic                           out_connected,
  input  logic                           cfg_we,
  input  logic [Z_W-1:0]                 cfg_wdata
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EVAL   = 4'd1;
  localparam logic [3:0] S_RATIO  = 4'd2;
  localparam logic [3:0] S_AVG    = 4'd3;
  localparam logic [3:0] S_DIVAVG = 4'd4;
  localparam logic [3:0] S_ZCHK   = 4'd5;
  localparam logic [3:0] S_SQRT   = 4'd6;
  localparam logic [3:0] S_LEVEL  = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0]                     state_r, state_nxt;
  logic signed [SAMPLE_WIDTH-1:0] v_r, v_nxt;
  logic signed [SAMPLE_WIDTH-1:0] i_r, i_nxt;
  logic                           lock_r, lock_nxt;
  logic signed [SAMPLE_WIDTH-1:0] last_v_r, last_v_nxt;
  logic signed [SAMPLE_WIDTH-1:0] last_i_r, last_i_nxt;
  logic signed [AVG_W-1:0]        avg_r, avg_nxt;
  logic signed [AVG_W-1:0]        ratio_r, ratio_nxt;
  logic [CNT_W-1:0]               count_r, count_nxt;
  logic [Z_W-1:0]                 held_r, held_nxt;
  logic [1:0]                     level_r, level_nxt;
  logic                           conn_held_r, conn_held_nxt;
  logic                           res_conn_r, res_conn_nxt;
  logic                           neg_r, neg_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [1:0]                     out_level_r, out_level_nxt;
  logic [Z_W-1:0]                 out_imp_r, out_imp_nxt;
  logic                           out_conn_r, out_conn_nxt;

  logic signed [SAMPLE_WIDTH:0]   dv, di;
  logic [SAMPLE_WIDTH:0]          dv_abs, di_abs;
  logic [SAMPLE_WIDTH-1:0]        dv_mag, di_mag;
  logic                           gate, conn_new;
  logic signed [T_W-1:0]          t;
  logic [T_W-1:0]                 t_mag;
  logic [DNUM_W-1:0]              avg_num;
  logic [AVG_W-1:0]               a_mag;
  logic                           a_big, count_full, slot_free;

  logic                           div_start;
  logic [DNUM_W-1:0]              div_num;
  logic [DDEN_W-1:0]              div_den;
  logic [AVG_W-1:0]               div_quo;
  unit_stat_t                     div_stat;
  logic                           sqrt_start;
  logic [ROOT_W:0]                sqrt_root;
  unit_stat_t                     sqrt_stat;

  function automatic logic signed [AVG_W-1:0] sat_apply(input logic neg,
                                                       input logic [AVG_W-1:0] m);
    logic signed [AVG_W-1:0] res;
    if (!neg) begin
      res = m[AVG_W-1] ? AVG_MAX_S : $signed(m);
    end else begin
      res = (m > {1'b1, {(AVG_W - 1){1'b0}}}) ? AVG_MIN_S : -$signed(m);
    end
    return res;
  endfunction

  function automatic logic [1:0] level_of(input logic [Z_W-1:0] z);
    logic [1:0] lvl;
    priority if (z <= Z_W'(Z_WEAK_MAX))   lvl = LVL_WEAK;
    else if (z <= Z_W'(Z_STRONG_MAX))     lvl = LVL_STRONG;
    else if (z <= Z_W'(Z_MARG_MAX))       lvl = LVL_MARGINAL;
    else                                  lvl = LVL_WEAK;
    return lvl;
  endfunction

  assign dv     = (SAMPLE_WIDTH + 1)'(v_r) - (SAMPLE_WIDTH + 1)'(last_v_r);
  assign di     = (SAMPLE_WIDTH + 1)'(i_r) - (SAMPLE_WIDTH + 1)'(last_i_r);
  assign dv_abs = dv[SAMPLE_WIDTH] ? -dv : dv;
  assign di_abs = di[SAMPLE_WIDTH] ? -di : di;
  assign dv_mag = dv_abs[SAMPLE_WIDTH-1:0];
  assign di_mag = di_abs[SAMPLE_WIDTH-1:0];
  assign gate   = (dv_mag > SAMPLE_WIDTH'(DV_MIN)) && (di_mag > SAMPLE_WIDTH'(DI_MIN));

  assign conn_new = (v_r > $signed(SAMPLE_WIDTH'(V_CONN_LO)))
                 && (v_r <= $signed(SAMPLE_WIDTH'(V_CONN_HI)));

  assign t       = (T_W'(avg_r) <<< 3) + T_W'(avg_r) + T_W'(ratio_r);
  assign t_mag   = t[T_W-1] ? -t : t;
  assign avg_num = DNUM_W'(t_mag + T_W'(AVG_ROUND));

  assign a_mag      = avg_r[AVG_W-1] ? -avg_r : avg_r;
  assign a_big      = a_mag > AVG_W'(Z_MAX);
  assign count_full = count_r >= CNT_W'(COUNT_LIMIT);
  assign slot_free  = !out_valid_r || out_ready;

  assign div_start  = ((state_r == S_EVAL) && lock_r && gate) || (state_r == S_AVG);
  assign div_num    = (state_r == S_AVG) ? avg_num : {dv_mag, {FRAC_BITS{1'b0}}};
  assign div_den    = (state_r == S_AVG) ? DDEN_W'(AVG_DIVISOR) : di_mag;
  assign sqrt_start = (state_r == S_ZCHK) && count_full && !a_big;

  wgic_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  wgic_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .a     (a_mag[Z_W-1:0]),
    .root  (sqrt_root),
    .stat  (sqrt_stat)
  );

  always_comb begin
    state_nxt     = state_r;
    v_nxt         = v_r;
    i_nxt         = i_r;
    lock_nxt      = lock_r;
    last_v_nxt    = last_v_r;
    last_i_nxt    = last_i_r;
    avg_nxt       = avg_r;
    ratio_nxt     = ratio_r;
    count_nxt     = count_r;
    held_nxt      = held_r;
    level_nxt     = level_r;
    conn_held_nxt = conn_held_r;
    res_conn_nxt  = res_conn_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_level_nxt = out_level_r;
    out_imp_nxt   = out_imp_r;
    out_conn_nxt  = out_conn_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          v_nxt     = in_grid_voltage;
          i_nxt     = in_current_out;
          lock_nxt  = in_pll_locked;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!lock_r) begin
          res_conn_nxt  = conn_held_r;
          conn_held_nxt = 1'b0;
          level_nxt     = LVL_WEAK;
          state_nxt     = S_OUT;
        end else begin
          conn_held_nxt = conn_new;
          res_conn_nxt  = conn_new;
          last_v_nxt    = v_r;
          last_i_nxt    = i_r;
          if (gate) begin
            neg_nxt   = dv[SAMPLE_WIDTH] ^ di[SAMPLE_WIDTH];
            state_nxt = S_RATIO;
          end else begin
            state_nxt = S_ZCHK;
          end
        end
      end
      S_RATIO: begin
        if (div_stat.done) begin
          ratio_nxt = sat_apply(neg_r, div_quo);
          state_nxt = S_AVG;
        end
      end
      S_AVG: begin
        neg_nxt   = t[T_W-1];
        state_nxt = S_DIVAVG;
      end
      S_DIVAVG: begin
        if (div_stat.done) begin
          avg_nxt = sat_apply(neg_r, div_quo);
          if (!count_full) begin
            count_nxt = count_r + 1'b1;
          end
          state_nxt = S_ZCHK;
        end
      end
      S_ZCHK: begin
        if (count_full && !a_big) begin
          state_nxt = S_SQRT;
        end else begin
          if (count_full) begin
            held_nxt = Z_MAX;
          end
          state_nxt = S_LEVEL;
        end
      end
      S_SQRT: begin
        if (sqrt_stat.done) begin
          held_nxt  = (sqrt_root > (ROOT_W + 1)'(Z_MAX)) ? Z_MAX : sqrt_root[Z_W-1:0];
          state_nxt = S_LEVEL;
        end
      end
      S_LEVEL: begin
        level_nxt = level_of(held_r);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = level_r;
          out_imp_nxt   = held_r;
          out_conn_nxt  = res_conn_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      held_nxt = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_v_r    <= SAMPLE_WIDTH'(ONE);
      last_i_r    <= '0;
      avg_r       <= '0;
      count_r     <= '0;
      held_r      <= '0;
      level_r     <= LVL_STRONG;
      conn_held_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_v_r    <= last_v_nxt;
      last_i_r    <= last_i_nxt;
      avg_r       <= avg_nxt;
      count_r     <= count_nxt;
      held_r      <= held_nxt;
      level_r     <= level_nxt;
      conn_held_r <= conn_held_nxt;
      out_valid_r <= out_valid_nxt;
    end
    v_r         <= v_nxt;
    i_r         <= i_nxt;
    lock_r      <= lock_nxt;
    ratio_r     <= ratio_nxt;
    res_conn_r  <= res_conn_nxt;
    neg_r       <= neg_nxt;
    out_level_r <= out_level_nxt;
    out_imp_r   <= out_imp_nxt;
    out_conn_r  <= out_conn_nxt;
  end

  assign in_ready               = (state_r == S_IDLE);
  assign out_valid              = out_valid_r;
  assign out_grid_level         = out_level_r;
  assign out_impedance_estimate = out_imp_r;
  assign out_connected          = out_conn_r;

  a_idle_units_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!div_stat.busy && !sqrt_stat.busy))
    else $error("arithmetic unit still running while the block is idle");

  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(COUNT_LIMIT))
    else $error("estimate count passed its limit");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while one is at work");

  a_result_posted: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_OUT) && slot_free) |=> (out_valid && in_ready))
    else $error("finished item not posted to the output register");

endmodule

@@ tb/tb_weak_grid_impedance_classifier.sv @@
// Self-checking testbench of the weak-grid impedance classifier, with its own classification predictor.
`timescale 1ns / 1ps

module tb_weak_grid_impedance_classifier;
  import wgic_pkg::*;

  localparam int     WATCHDOG_LIMIT = 4000;
  localparam int     SETTLE_CYCLES  = 50;
  localparam longint AVG_HI         = (longint'(1) << (AVG_W - 1)) - 1;
  localparam longint AVG_LO         = -AVG_HI - 1;
  localparam longint Z_TOP          = (longint'(1) << Z_W) - 1;

  typedef struct {
    logic [1:0]     level;
    logic [Z_W-1:0] impedance;
    logic           connected;
  } grid_result_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  logic signed [SAMPLE_WIDTH-1:0] in_grid_voltage;
  logic signed [SAMPLE_WIDTH-1:0] in_current_out;
  logic                           in_pll_locked;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [1:0]                     out_grid_level;
  logic [Z_W-1:0]                 out_impedance_estimate;
  logic                           out_connected;
  logic                           cfg_we;
  logic [Z_W-1:0]                 cfg_wdata;

  grid_result_t   grid_results_due[$];
  int             mismatch_count = 0;
  int             quiet_cycles = 0;
  int             ready_hold = 0;
  bit             send_idle_on = 1'b1;
  bit             sink_idle_on = 1'b1;

  longint         prev_voltage;
  longint         prev_current;
  longint         ratio_avg;
  int             ratio_count;
  logic [Z_W-1:0] z_held;
  logic           conn_held;

  weak_grid_impedance_classifier uut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_grid_voltage        (in_grid_voltage),
    .in_current_out         (in_current_out),
    .in_pll_locked          (in_pll_locked),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_grid_level         (out_grid_level),
    .out_impedance_estimate (out_impedance_estimate),
    .out_connected          (out_connected),
    .cfg_we                 (cfg_we),
    .cfg_wdata              (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic longint clamp_avg(input longint x);
    if (x > AVG_HI) return AVG_HI;
    if (x < AVG_LO) return AVG_LO;
    return x;
  endfunction

  function automatic grid_result_t classify_sample(input logic signed [SAMPLE_WIDTH-1:0] v_in,
                                                   input logic signed [SAMPLE_WIDTH-1:0] i_in,
                                                   input logic locked);
    grid_result_t r;
    longint       v;
    longint       i;
    longint       dv;
    longint       di;
    longint       q;
    longint       t;
    longint       a;
    longint       x;
    longint       root;
    longint       zl;
    int           b;
    v = v_in;
    i = i_in;
    if (!locked) begin
      r.level     = LVL_WEAK;
      r.impedance = z_held;
      r.connected = conn_held;
      conn_held   = 1'b0;
      return r;
    end
    conn_held = (5 * v > 4 * ONE) && (5 * v < 6 * ONE);
    dv = v - prev_voltage;
    di = i - prev_current;
    prev_voltage = v;
    prev_current = i;
    if (((di < 0) ? -di : di) * 100 > ONE && ((dv < 0) ? -dv : dv) * 1000 > ONE) begin
      q = clamp_avg((dv * ONE) / di);
      t = 9 * ratio_avg + q;
      q = (t >= 0) ? (t + 5) / 10 : -((-t + 5) / 10);
      ratio_avg = clamp_avg(q);
      if (ratio_count < COUNT_LIMIT) ratio_count++;
    end
    if (ratio_count >= COUNT_LIMIT) begin
      a = (ratio_avg < 0) ? -ratio_avg : ratio_avg;
      if (a > Z_TOP) begin
        z_held = Z_W'(Z_TOP);
      end else begin
        x = 2 * a * a;
        root = 0;
        for (b = 15; b >= 0; b--) begin
          if ((root | (longint'(1) << b)) * (root | (longint'(1) << b)) <= x)
            root = root | (longint'(1) << b);
        end
        if (x - root * root > root) root++;
        z_held = Z_W'((root > Z_TOP) ? Z_TOP : root);
      end
    end
    zl = z_held;
    if (zl * 100 <= ONE) r.level = LVL_WEAK;
    else if (zl * 3 < ONE) r.level = LVL_STRONG;
    else if (zl * 2 < ONE) r.level = LVL_MARGINAL;
    else r.level = LVL_WEAK;
    r.impedance = z_held;
    r.connected = conn_held;
    return r;
  endfunction

  task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] v,
                             input logic signed [SAMPLE_WIDTH-1:0] i,
                             input logic locked);
    if (send_idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_grid_voltage <= v;
    in_current_out  <= i;
    in_pll_locked   <= locked;
    do @(posedge clk); while (!in_ready);
    grid_results_due.push_back(classify_sample(v, i, locked));
  endtask

  task automatic wait_for_results;
    in_valid <= 1'b0;
    while (grid_results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_z_initial(input logic [Z_W-1:0] z);
    cfg_we    <= 1'b1;
    cfg_wdata <= z;
    @(posedge clk);
    cfg_we <= 1'b0;
    z_held = z;
  endtask

  task automatic test_after_reset;
    send_sample(16'sd4096, 16'sd0, 1'b1);
    send_sample(16'sd0, 16'sd0, 1'b0);
  endtask

  task automatic test_level_thresholds;
    logic [Z_W-1:0] z;
    int             k;
    for (k = 0; k < 7; k++) begin
      case (k)
        0: z = 15'd0;
        1: z = 15'd40;
        2: z = 15'd41;
        3: z = 15'd1365;
        4: z = 15'd1366;
        5: z = 15'd2047;
        default: z = 15'd2048;
      endcase
      wait_for_results;
      load_z_initial(z);
      send_sample(SAMPLE_WIDTH'(prev_voltage), SAMPLE_WIDTH'(prev_current), 1'b1);
    end
    send_sample(SAMPLE_WIDTH'(prev_voltage), SAMPLE_WIDTH'(prev_current), 1'b0);
  endtask

  task automatic test_connection_window;
    logic signed [SAMPLE_WIDTH-1:0] i;
    i = SAMPLE_WIDTH'(prev_current);
    send_sample(16'sd3276, i, 1'b1);
    send_sample(16'sd3277, i, 1'b1);
    send_sample(16'sh7fff, 16'sh8000, 1'b0);
    send_sample(16'sh8000, 16'sh7fff, 1'b0);
    send_sample(16'sd4916, i, 1'b1);
    send_sample(16'sd4915, i, 1'b1);
    send_sample(16'sh8000, i, 1'b1);
    send_sample(16'sh7fff, i, 1'b1);
  endtask

  task automatic test_delta_gate;
    send_sample(16'sd4096, 16'sd41, 1'b1);
    send_sample(16'sd4101, 16'sd82, 1'b1);
    send_sample(16'sd4105, 16'sd200, 1'b1);
    send_sample(16'sd4205, 16'sd240, 1'b1);
    send_sample(16'sh8000, 16'sh8000, 1'b1);
    send_sample(16'sh7fff, 16'sh7fff, 1'b1);
  endtask

  task automatic test_random_traffic;
    logic signed [SAMPLE_WIDTH-1:0] v;
    logic signed [SAMPLE_WIDTH-1:0] i;
    logic                           locked;
    logic [Z_W-1:0]                 z;
    int                             phase;
    int                             n;
    int                             count;
    int                             kind;
    int                             span;
    int                             vv;
    for (phase = 0; phase < 7; phase++) begin
      case (phase)
        0: z = 15'h7fff;
        1: z = 15'd0;
        3: z = 15'd41;
        4: z = 15'd2048;
        default: z = Z_W'($urandom);
      endcase
      wait_for_results;
      load_z_initial(z);
      send_idle_on = (phase != 2) && (phase < 6);
      sink_idle_on = (phase != 4) && (phase < 6);
      span  = (phase % 3 == 0) ? 2000 : ((phase % 3 == 1) ? 8000 : 30000);
      count = (phase < 6) ? 200 : 150;
      for (n = 0; n < count; n++) begin
        if (phase == 1 && n == 100) wait_for_results;
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
          vv = int'(prev_voltage) + int'($urandom_range(0, 600)) - 300;
          if (vv < 2600) vv = 2600;
          if (vv > 5600) vv = 5600;
          v = SAMPLE_WIDTH'(vv);
          i = SAMPLE_WIDTH'(int'($urandom_range(0, 2 * span)) - span);
          locked = 1'b1;
        end else if (kind < 70) begin
          v = SAMPLE_WIDTH'(prev_voltage + int'($urandom_range(0, 40)) - 20);
          i = SAMPLE_WIDTH'(prev_current);
          locked = 1'b1;
        end else if (kind < 85) begin
          v = SAMPLE_WIDTH'($urandom);
          i = SAMPLE_WIDTH'($urandom);
          locked = 1'b0;
        end else begin
          v = SAMPLE_WIDTH'($urandom);
          i = SAMPLE_WIDTH'($urandom);
          locked = 1'b1;
        end
        send_sample(v, i, locked);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!sink_idle_on) begin
      out_ready  <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      out_ready  <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_ready  <= 1'b0;
      ready_hold <= $urandom_range(0, 5);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    grid_result_t due;
    if (rst_n && out_valid && out_ready) begin
      if (grid_results_due.size() == 0) begin
        $error("result item with no input item outstanding");
        mismatch_count++;
      end else begin
        due = grid_results_due.pop_front();
        if (out_grid_level !== due.level) begin
          $error("grid_level: expected %0d, got %0d", due.level, out_grid_level);
          mismatch_count++;
        end
        if (out_impedance_estimate !== due.impedance) begin
          $error("impedance_estimate: expected %0d, got %0d", due.impedance,
                 out_impedance_estimate);
          mismatch_count++;
        end
        if (out_connected !== due.connected) begin
          $error("connected: expected %0d, got %0d", due.connected, out_connected);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("weak_grid_impedance_classifier regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_grid_voltage <= '0;
    in_current_out  <= '0;
    in_pll_locked   <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    prev_voltage = ONE;
    prev_current = 0;
    ratio_avg    = 0;
    ratio_count  = 0;
    z_held       = '0;
    conn_held    = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_after_reset;
    test_level_thresholds;
    test_connection_window;
    test_delta_gate;
    test_random_traffic;
    wait_for_results;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("weak_grid_impedance_classifier regression: pass");
    else $display("weak_grid_impedance_classifier regression: fail");
    $finish;
  end

endmodule
